FILE: sv/scal_pkg.sv
// shared types, widths and helpers for the static coarse alignment block
package scal_pkg;

  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DAT_W       = 32;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned MEAN_W      = 34;
  localparam int unsigned PROD_W      = 2 * MEAN_W;
  localparam int unsigned VEC_W       = 66;
  localparam int unsigned MAG_W       = 64;
  localparam int unsigned DVD_W       = 64;
  localparam int unsigned DVS_W       = 32;

  localparam logic ACT_ACCUM   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef enum logic [1:0] {
    CFG_WIN_START = 2'd0,
    CFG_WIN_END   = 2'd1,
    CFG_GYRO_LIM  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DEGEN = 2'd2
  } status_e;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic              action;
    logic [31:0]       sample_time;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    sum_t [2:0]       gyro;
    sum_t [2:0]       accel;
    logic [CNT_W-1:0] count;
  } acc_state_t;

  // operand order of the six cross product terms
  function automatic logic [1:0] cross_a_idx(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_b_idx(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/scal_div.sv
// iterative restoring divider, one quotient bit per cycle
module scal_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [scal_pkg::DVD_W-1:0]   dividend_i,
  input  logic [scal_pkg::DVS_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [scal_pkg::DVD_W-1:0]   quotient_o
);

  localparam int unsigned CW = $clog2(scal_pkg::DVD_W);

  logic                       busy_q, done_q;
  logic [CW-1:0]              cnt_q;
  logic [scal_pkg::DVS_W-1:0] rem_q, dvs_q;
  logic [scal_pkg::DVD_W-1:0] quo_q;
  logic [scal_pkg::DVS_W:0]   trial, diff;
  logic                       fits;

  always_comb begin
    trial = {rem_q, quo_q[scal_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(scal_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[scal_pkg::DVS_W-1:0] : trial[scal_pkg::DVS_W-1:0];
      quo_q <= {quo_q[scal_pkg::DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/scal_isqrt.sv
// iterative floor square root of a 64 bit word, two radicand bits per cycle
module scal_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [63:0] bit_q, x_q, r_q;
  logic [64:0] t;
  logic        take;

  always_comb begin
    t    = {1'b0, r_q} + {1'b0, bit_q};
    take = {1'b0, x_q} >= t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= 64'd1 << 62;
      end else if (busy_q) begin
        bit_q <= bit_q >> 2;
        if (bit_q == 64'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= radicand_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (take) begin
        x_q <= x_q - t[63:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

FILE: sv/scal_accum.sv
// configuration registers and windowed sample accumulator
module scal_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 sample_i,
  input  scal_pkg::in_item_t   item_i,
  input  logic                 clear_i,
  output scal_pkg::acc_state_t acc_o
);

  localparam int unsigned EXT = scal_pkg::SUM_W - scal_pkg::DAT_W;

  logic [31:0]          win_start_q, win_end_q, gyro_lim_q;
  scal_pkg::acc_state_t acc_q;
  logic                 take;
  logic [2:0][31:0]     gin, ain;

  always_comb begin
    gin  = {item_i.gyro_z, item_i.gyro_y, item_i.gyro_x};
    ain  = {item_i.accel_z, item_i.accel_y, item_i.accel_x};
    take = sample_i
        && (item_i.sample_time >= win_start_q)
        && (item_i.sample_time <= win_end_q)
        && ($signed(item_i.gyro_x) <= $signed(gyro_lim_q))
        && (acc_q.count < scal_pkg::CNT_W'(scal_pkg::MAX_SAMPLES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '1;
      gyro_lim_q  <= 32'd26214;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scal_pkg::CFG_WIN_START: win_start_q <= cfg_data_i;
        scal_pkg::CFG_WIN_END:   win_end_q   <= cfg_data_i;
        scal_pkg::CFG_GYRO_LIM:  gyro_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
    end else if (take) begin
      for (int i = 0; i < 3; i++) begin
        acc_q.gyro[i]  <= acc_q.gyro[i]  + {{EXT{gin[i][31]}}, gin[i]};
        acc_q.accel[i] <= acc_q.accel[i] + {{EXT{ain[i][31]}}, ain[i]};
      end
      acc_q.count <= acc_q.count + 1'b1;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: sv/static_coarse_alignment.sv
// top level: sample accumulation and sequenced attitude matrix computation
//
// input channel: one beat per item (in_valid_i / in_stall_o). an accumulate
// beat is taken while idle and adds the sample to the sums when its time
// lies in the window, its gyro x is not above the limit and the sums are
// not full. a compute beat starts the sequencer and the block stalls input
// until all nine result beats are delivered.
// output channel: nine beats per compute (out_valid_o / out_stall_i), the
// attitude matrix row-major, last set on the ninth. out_valid_o holds while
// the receiver stalls; each beat waits for the one before.
// a compute runs the six means and then nine unit components on the shared
// 64 step divider, the norms on the 32 step square root, and up to 1, 33
// and 31 normalize shifts for the three vectors. the results then leave at
// one result beat per cycle while not stalled.
// with zero samples a compute beat goes straight to output in the next cycle.
// reset clears sums, count and sequencer, and loads the register defaults.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i.
module static_coarse_alignment (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scal_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scal_pkg::out_item_t out_data_o
);

  localparam int unsigned MW = scal_pkg::MEAN_W;
  localparam int unsigned VW = scal_pkg::VEC_W;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_MEAN_GO   = 14'b00000000000010,
    S_MEAN_WAIT = 14'b00000000000100,
    S_LOAD      = 14'b00000000001000,
    S_SHIFT     = 14'b00000000010000,
    S_SQ_MUL    = 14'b00000000100000,
    S_SQ_ACC    = 14'b00000001000000,
    S_SQRT_GO   = 14'b00000010000000,
    S_SQRT_WAIT = 14'b00000100000000,
    S_DIV_GO    = 14'b00001000000000,
    S_DIV_WAIT  = 14'b00010000000000,
    S_CROSS_MUL = 14'b00100000000000,
    S_CROSS_ACC = 14'b01000000000000,
    S_EMIT      = 14'b10000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [1:0] i_q, i_d, tgt_q, tgt_d, status_q, status_d;
  logic [3:0] eidx_q, eidx_d;
  logic       clear_acc;

  // datapath registers
  logic signed [MW-1:0]              g_q [3];
  logic signed [MW-1:0]              w_q [3];
  logic signed [VW-1:0]              v_q [3];
  logic [scal_pkg::MAG_W-1:0]        m_q [3];
  logic [2:0]                        neg_q;
  logic [63:0]                       sq_q;
  logic [31:0]                       n_q;
  logic signed [31:0]                u_q [3][3];
  logic signed [31:0]                mat_q [9];
  logic signed [scal_pkg::PROD_W-1:0] prod_q, prod_d;

  scal_pkg::acc_state_t acc;
  logic                 in_acc, compute_acc, sample_acc, out_acc;

  // shared unit hookups
  logic                       div_start, div_done;
  logic [scal_pkg::DVD_W-1:0] div_dividend, div_quot;
  logic [scal_pkg::DVS_W-1:0] div_divisor;
  logic                       sqrt_start, sqrt_done;
  logic [31:0]                sqrt_root;
  logic signed [MW-1:0]       mul_a, mul_b;

  // selected sum for the mean divisions
  scal_pkg::sum_t       sum_sel;
  logic [2:0]           kk;
  logic [scal_pkg::SUM_W-1:0] sum_mag;
  logic [MW-1:0]        q_mean;
  logic [31:0]          q_unit;
  logic signed [31:0]   u_new;
  logic                 any_big;
  logic [1:0]           ai, bi;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign compute_acc = in_acc && (in_data_i.action == scal_pkg::ACT_COMPUTE);
  assign sample_acc  = in_acc && (in_data_i.action == scal_pkg::ACT_ACCUM);
  assign out_acc     = out_valid_o && !out_stall_i;

  scal_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_acc),
    .item_i     (in_data_i),
    .clear_i    (clear_acc),
    .acc_o      (acc)
  );

  scal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  scal_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  always_comb begin
    kk      = k_q - 3'd3;
    sum_sel = (k_q < 3'd3) ? acc.gyro[k_q[1:0]] : acc.accel[kk[1:0]];
    sum_mag = sum_sel[scal_pkg::SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
    q_mean  = div_quot[MW-1:0];
    q_unit  = div_quot[31:0];
    u_new   = neg_q[i_q] ? -$signed(q_unit) : $signed(q_unit);
    any_big = (|m_q[0][63:31]) || (|m_q[1][63:31]) || (|m_q[2][63:31]);
    ai      = scal_pkg::cross_a_idx(k_q);
    bi      = scal_pkg::cross_b_idx(k_q);
  end

  // divider operands: either a sum magnitude over the count, or a scaled
  // component magnitude over the norm with half the norm added for rounding
  always_comb begin
    div_start  = (state_q == S_MEAN_GO) || (state_q == S_DIV_GO);
    sqrt_start = (state_q == S_SQRT_GO);
    if (state_q == S_MEAN_GO) begin
      div_dividend = scal_pkg::DVD_W'(sum_mag);
      div_divisor  = scal_pkg::DVS_W'(acc.count);
    end else begin
      div_dividend = scal_pkg::DVD_W'({m_q[i_q][30:0], 30'd0})
                   + scal_pkg::DVD_W'(n_q >> 1);
      div_divisor  = n_q;
    end
  end

  // shared multiplier: squares of normalized magnitudes or cross terms
  always_comb begin
    if (state_q == S_SQ_MUL) begin
      mul_a = $signed({{(MW-31){1'b0}}, m_q[i_q][30:0]});
      mul_b = mul_a;
    end else if (tgt_q == 2'd1) begin
      mul_a = g_q[ai];
      mul_b = w_q[bi];
    end else begin
      mul_a = {{(MW-32){u_q[1][ai][31]}}, u_q[1][ai]};
      mul_b = {{(MW-32){u_q[0][bi][31]}}, u_q[0][bi]};
    end
    prod_d = mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    i_d       = i_q;
    tgt_d     = tgt_q;
    eidx_d    = eidx_q;
    status_d  = status_q;
    clear_acc = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (compute_acc) begin
          if (acc.count == '0) begin
            status_d  = scal_pkg::ST_EMPTY;
            eidx_d    = '0;
            clear_acc = 1'b1;
            state_d   = S_EMIT;
          end else begin
            k_d     = '0;
            state_d = S_MEAN_GO;
          end
        end
      end
      S_MEAN_GO: state_d = S_MEAN_WAIT;
      S_MEAN_WAIT: begin
        if (div_done) begin
          if (k_q == 3'd5) begin
            tgt_d   = 2'd0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_MEAN_GO;
          end
        end
      end
      S_LOAD: state_d = S_SHIFT;
      S_SHIFT: begin
        if (!any_big) begin
          i_d     = '0;
          state_d = S_SQ_MUL;
        end
      end
      S_SQ_MUL: state_d = S_SQ_ACC;
      S_SQ_ACC: begin
        if (i_q == 2'd2) begin
          state_d = S_SQRT_GO;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SQ_MUL;
        end
      end
      S_SQRT_GO: state_d = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          if (sqrt_root == '0) begin
            status_d  = scal_pkg::ST_DEGEN;
            eidx_d    = '0;
            clear_acc = 1'b1;
            state_d   = S_EMIT;
          end else begin
            i_d     = '0;
            state_d = S_DIV_GO;
          end
        end
      end
      S_DIV_GO: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          if (i_q != 2'd2) begin
            i_d     = i_q + 1'b1;
            state_d = S_DIV_GO;
          end else if (tgt_q == 2'd2) begin
            status_d  = scal_pkg::ST_OK;
            eidx_d    = '0;
            clear_acc = 1'b1;
            state_d   = S_EMIT;
          end else begin
            tgt_d   = tgt_q + 1'b1;
            k_d     = '0;
            state_d = S_CROSS_MUL;
          end
        end
      end
      S_CROSS_MUL: state_d = S_CROSS_ACC;
      S_CROSS_ACC: begin
        if (k_q == 3'd5) begin
          state_d = S_LOAD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_CROSS_MUL;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (eidx_q == 4'd8) begin
            state_d = S_IDLE;
          end else begin
            eidx_d = eidx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      i_q      <= '0;
      tgt_q    <= '0;
      eidx_q   <= '0;
      status_q <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      i_q      <= i_d;
      tgt_q    <= tgt_d;
      eidx_q   <= eidx_d;
      status_q <= status_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic signed [VW-1:0] val;
    logic signed [VW-1:0] mag;
    prod_q <= prod_d;
    unique case (state_q)
      S_IDLE: begin
        if (compute_acc) begin
          for (int j = 0; j < 9; j++) mat_q[j] <= '0;
        end
      end
      S_MEAN_WAIT: begin
        if (div_done) begin
          // truncation toward zero, gravity is the negated accel mean
          if (k_q < 3'd3) begin
            w_q[k_q[1:0]] <= sum_sel[scal_pkg::SUM_W-1] ? -$signed(q_mean)
                                                        : $signed(q_mean);
          end else begin
            g_q[kk[1:0]]  <= sum_sel[scal_pkg::SUM_W-1] ? $signed(q_mean)
                                                        : -$signed(q_mean);
          end
        end
      end
      S_LOAD: begin
        sq_q <= '0;
        for (int j = 0; j < 3; j++) begin
          val = (tgt_q == 2'd0) ? {{(VW-MW){g_q[j][MW-1]}}, g_q[j]} : v_q[j];
          mag = val[VW-1] ? -val : val;
          neg_q[j] <= val[VW-1];
          m_q[j]   <= mag[scal_pkg::MAG_W-1:0];
        end
      end
      S_SHIFT: begin
        if (any_big) begin
          for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] >> 1;
        end
      end
      S_SQ_ACC: sq_q <= sq_q + prod_q[63:0];
      S_SQRT_WAIT: begin
        if (sqrt_done) n_q <= sqrt_root;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          u_q[tgt_q][i_q] <= u_new;
          if (i_q == 2'd2 && tgt_q == 2'd2) begin
            for (int j = 0; j < 3; j++) begin
              mat_q[j]     <= u_q[1][j];
              mat_q[6 + j] <= -u_q[0][j];
            end
            mat_q[3] <= u_q[2][0];
            mat_q[4] <= u_q[2][1];
            mat_q[5] <= u_new;
          end
        end
      end
      S_CROSS_ACC: begin
        if (k_q[0]) begin
          v_q[k_q[2:1]] <= v_q[k_q[2:1]] - prod_q[VW-1:0];
        end else begin
          v_q[k_q[2:1]] <= prod_q[VW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  always_comb begin
    out_data_o.element_index = eidx_q;
    out_data_o.element_value = mat_q[eidx_q];
    out_data_o.status        = status_q;
    out_data_o.last          = (eidx_q == 4'd8);
  end

  // no input beat is taken while results are pending
  a_no_accept_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("input accepted while emitting");

  // an error status always comes with zero values
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != scal_pkg::ST_OK)
      |-> (out_data_o.element_value == '0))
    else $error("nonzero value with error status");

  // after the last beat the run is over
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.last) |=> (!out_valid_o && !in_stall_o))
    else $error("output continued after last beat");

  // sums are empty once a run starts emitting
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o)) |-> (acc.count == '0))
    else $error("accumulator not cleared by compute");

endmodule
